/* sv/sitda_pkg.sv */
// shared types and constants for the signed integer to decimal text converter
package sitda_pkg;

    // default width of the signed input value
    localparam int VALUE_WIDTH_DEF = 32;

    // ascii codes and digit limits
    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] MINUS_CHAR  = 8'd45;
    localparam logic [3:0] BCD_THRESH  = 4'd5;
    localparam logic [3:0] BCD_ADJUST  = 4'd3;
    localparam int         COUNT_WIDTH = 4;

    // command from the sequencer to every digit cell
    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift;
    } sitda_cmd_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_EMIT
    } sitda_state_t;

endpackage

/* sv/sitda_cell.sv */
// one bcd digit cell of the double-dabble chain
module sitda_cell (
    input  logic              clk,
    input  sitda_pkg::sitda_cmd_t cmd,
    input  logic              bit_in,
    input  logic [3:0]        digit_in,
    output logic              bit_out,
    output logic [3:0]        digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // add three when the digit is five or more, before the shift
    assign adj     = (digit_reg >= sitda_pkg::BCD_THRESH) ?
                     4'(digit_reg + sitda_pkg::BCD_ADJUST) : digit_reg;
    assign bit_out = adj[3];
    assign digit   = digit_reg;

    // clear on a new value, bit shift while converting, digit shift while emitting
    always_comb
    begin
        digit_next = digit_reg;
        if (cmd.clear)
        begin
            digit_next = 4'd0;
        end
        else if (cmd.dabble)
        begin
            digit_next = {adj[2:0], bit_in};
        end
        else if (cmd.shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

/* sv/sitda_ctrl.sv */
// sequencer: takes the value, drives the cell chain and emits the characters
module sitda_ctrl #(
    parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF,
    parameter int NUM_DIGITS  = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // input value
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [VALUE_WIDTH-1:0] in_value,
    // cell chain
    output sitda_pkg::sitda_cmd_t  cmd,
    output logic                   chain_bit,
    input  logic [3:0]             top_digit,
    // character output
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_char,
    output logic                   out_last,
    output logic [sitda_pkg::COUNT_WIDTH-1:0] out_count
);

    localparam int BW = $clog2(VALUE_WIDTH + 1);
    localparam int RW = $clog2(NUM_DIGITS + 1);
    localparam int CW = sitda_pkg::COUNT_WIDTH;

    sitda_pkg::sitda_state_t state_reg, state_next;

    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [BW-1:0]          bit_cnt_reg, bit_cnt_next;
    logic [RW-1:0]          rem_reg, rem_next;
    logic                   started_reg, started_next;
    logic [RW-1:0]          printed_reg, printed_next;
    logic                   ovalid_reg, ovalid_next;
    logic [7:0]             ochar_reg, ochar_next;
    logic                   olast_reg, olast_next;
    logic [CW-1:0]          ocount_reg, ocount_next;

    logic                   accept;
    logic                   out_free;
    logic                   skip_zero;
    logic                   last_digit;
    logic [RW-1:0]          printed_now;
    logic [RW+CW-1:0]       count_wide;
    logic [VALUE_WIDTH-1:0] mag_in;

    assign accept      = in_valid && (state_reg == sitda_pkg::ST_IDLE);
    assign out_free    = !ovalid_reg || out_ready;
    assign skip_zero   = !started_reg && (top_digit == 4'd0) && (rem_reg > RW'(1));
    assign last_digit  = (rem_reg == RW'(1));
    assign printed_now = started_reg ? printed_reg : rem_reg;
    assign count_wide  = {{CW{1'b0}}, printed_now};
    assign mag_in      = in_value[VALUE_WIDTH-1] ? VALUE_WIDTH'(~in_value + 1'b1) : in_value;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sitda_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sitda_pkg::ST_CONV;
                end
            end
            sitda_pkg::ST_CONV:
            begin
                if (bit_cnt_reg == BW'(1))
                begin
                    state_next = neg_reg ? sitda_pkg::ST_SIGN : sitda_pkg::ST_EMIT;
                end
            end
            sitda_pkg::ST_SIGN:
            begin
                if (out_free)
                begin
                    state_next = sitda_pkg::ST_EMIT;
                end
            end
            sitda_pkg::ST_EMIT:
            begin
                if (!skip_zero && out_free && last_digit)
                begin
                    state_next = sitda_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sitda_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        cmd          = '0;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        bit_cnt_next = bit_cnt_reg;
        rem_next     = rem_reg;
        started_next = started_reg;
        printed_next = printed_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        ochar_next   = ochar_reg;
        olast_next   = olast_reg;
        ocount_next  = ocount_reg;
        case (state_reg)
            sitda_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.clear    = 1'b1;
                    mag_next     = mag_in;
                    neg_next     = in_value[VALUE_WIDTH-1];
                    bit_cnt_next = BW'(VALUE_WIDTH);
                end
            end
            sitda_pkg::ST_CONV:
            begin
                cmd.dabble   = 1'b1;
                mag_next     = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - BW'(1);
                rem_next     = RW'(NUM_DIGITS);
                started_next = 1'b0;
            end
            sitda_pkg::ST_SIGN:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ochar_next  = sitda_pkg::MINUS_CHAR;
                    olast_next  = 1'b0;
                    ocount_next = '0;
                end
            end
            sitda_pkg::ST_EMIT:
            begin
                if (skip_zero)
                begin
                    // drop a leading zero digit
                    cmd.shift = 1'b1;
                    rem_next  = rem_reg - RW'(1);
                end
                else if (out_free)
                begin
                    cmd.shift    = 1'b1;
                    rem_next     = rem_reg - RW'(1);
                    started_next = 1'b1;
                    printed_next = printed_now;
                    ovalid_next  = 1'b1;
                    ochar_next   = sitda_pkg::ASCII_ZERO | {4'd0, top_digit};
                    olast_next   = last_digit;
                    ocount_next  = last_digit ? count_wide[CW-1:0] : '0;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // control and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sitda_pkg::ST_IDLE;
            ovalid_reg  <= 1'b0;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ovalid_reg  <= ovalid_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        bit_cnt_reg <= bit_cnt_next;
        rem_reg     <= rem_next;
        printed_reg <= printed_next;
        ochar_reg   <= ochar_next;
        olast_reg   <= olast_next;
        ocount_reg  <= ocount_next;
    end

    assign in_ready  = (state_reg == sitda_pkg::ST_IDLE);
    assign chain_bit = mag_reg[VALUE_WIDTH-1];
    assign out_valid = ovalid_reg;
    assign out_char  = ochar_reg;
    assign out_last  = olast_reg;
    assign out_count = ocount_reg;

endmodule

/* sv/signed_int_to_decimal_ascii_top.sv */
// top level: signed integer to decimal ascii characters over a bcd cell chain
//
//  channel   dir  tdata                tlast       tuser
//  s_axis    in   value [W-1:0]        -           -
//  m_axis    out  out_char [7:0]       last_char   digit_count [3:0]
//
// a value is accepted, then takes VALUE_WIDTH double-dabble steps in the digit
// chain; then a minus sign goes out for a negative value, leading zero digits
// are dropped and each remaining digit goes out as a character beat.
// one value is in work at a time.
// a stalled m_tready holds the character register and pauses the emit.
// rst_n clears the sequencer and the output valid asynchronously.
module signed_int_to_decimal_ascii_top #(
    parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]  s_tdata,   // value
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // out_char
    output logic                              m_tlast,
    output logic [3:0]                        m_tuser    // digit_count
);

    // decimal digits of 2^(VALUE_WIDTH-1)
    localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;

    sitda_pkg::sitda_cmd_t cmd;
    logic                  chain_bit;
    logic                  cell_bit   [NUM_DIGITS];
    logic [3:0]            cell_digit [NUM_DIGITS];

    // sequencer
    sitda_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (NUM_DIGITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata[VALUE_WIDTH-1:0]),
        .cmd       (cmd),
        .chain_bit (chain_bit),
        .top_digit (cell_digit[NUM_DIGITS-1]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast),
        .out_count (m_tuser)
    );

    // digit cells, least significant first
    for (genvar i = 0; i < NUM_DIGITS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            sitda_cell u_cell (
                .clk      (clk),
                .cmd      (cmd),
                .bit_in   (chain_bit),
                .digit_in (4'd0),
                .bit_out  (cell_bit[i]),
                .digit    (cell_digit[i])
            );
        end
        else
        begin : g_rest
            sitda_cell u_cell (
                .clk      (clk),
                .cmd      (cmd),
                .bit_in   (cell_bit[i-1]),
                .digit_in (cell_digit[i-1]),
                .bit_out  (cell_bit[i]),
                .digit    (cell_digit[i])
            );
        end
    end

    // the top cell never carries out during conversion
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dabble |-> !cell_bit[NUM_DIGITS-1])
        else $error("digit chain overflow");

    // a beat still waiting while idle must be the final character
    a_idle_pending_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tready && m_tvalid) |-> m_tlast)
        else $error("idle with a non-final character pending");

    // the final character is a digit and counts at least one digit
    a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata != sitda_pkg::MINUS_CHAR && m_tuser != 4'd0))
        else $error("bad final character");

    // no new value is taken while the chain is converting
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dabble |-> !s_tready)
        else $error("ready during conversion");

endmodule

/* dv/signed_int_to_decimal_ascii_top_test.sv */
// self-checking testbench for the signed integer to decimal ascii converter
module signed_int_to_decimal_ascii_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW           = sitda_pkg::VALUE_WIDTH_DEF;
    localparam int DATA_W       = ((VW + 7) / 8) * 8;
    localparam int NUM_ROWS     = 24;
    localparam int DRAIN_CYCLES = 60;
    localparam int LIMIT_CYCLES = 400000;
    localparam logic [7:0] RADIX = 8'd10;

    // handshake pressure of each phase of the run
    typedef enum logic [1:0] {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH
    } pace_t;

    // one character beat on the output stream
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [3:0] count;
    } char_beat_t;

    // one queued value, with its directed row when the text is typed in
    typedef struct packed {
        logic [VW-1:0] value;
        logic          typed;
        logic [4:0]    row;
        pace_t         pace;
    } value_item_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;      // value
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;            // out_char
    logic              m_tlast;
    logic [3:0]        m_tuser;            // digit_count

    logic [VW-1:0] row_value [NUM_ROWS];
    string         row_text  [NUM_ROWS];

    value_item_t   pending_values[$];
    char_beat_t    expected_chars[$];
    value_item_t   presented;
    pace_t         cur_pace     = PH_FREE;

    int            error_count  = 0;
    int            cycle_count  = 0;
    int            values_sent  = 0;
    int            negatives    = 0;
    int            beats_seen   = 0;
    int            numbers_seen = 0;
    bit            drained      = 1'b0;

    signed_int_to_decimal_ascii_top #(
        .VALUE_WIDTH (VW)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("ERROR cycle %0d: %s: got %0d, expected %0d", cycle_count, what, got, want);
        error_count++;
    endtask

    // decimal text of one value: sign, then digits most significant first
    function automatic void predict_decimal_text(logic [VW-1:0] value);
        logic          neg;
        logic [VW-1:0] mag;
        logic [3:0]    digits[20];
        int            nd;
        neg = value[VW-1];
        mag = neg ? (~value + 1'b1) : value;
        nd  = 0;
        do
        begin
            digits[nd] = 4'(mag % RADIX);
            mag        = mag / RADIX;
            nd++;
        end
        while (mag != 0);
        if (neg)
            expected_chars.push_back('{sitda_pkg::MINUS_CHAR, 1'b0, 4'd0});
        for (int i = nd - 1; i >= 0; i--)
            expected_chars.push_back('{sitda_pkg::ASCII_ZERO + 8'(digits[i]), i == 0,
                                       (i == 0) ? 4'(nd) : 4'd0});
    endfunction

    // typed-in text of a directed row, turned into character beats
    function automatic void push_typed_text(string text);
        int len;
        int nd;
        len = text.len();
        nd  = (text[0] == "-") ? len - 1 : len;
        for (int i = 0; i < len; i++)
            expected_chars.push_back('{8'(text[i]), i == len - 1,
                                       (i == len - 1) ? 4'(nd) : 4'd0});
    endfunction

    function automatic int send_idle_pct(pace_t p);
        case (p)
            PH_SEND_IDLE: return 53;
            PH_BOTH:      return 29;
            default:      return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(pace_t p);
        case (p)
            PH_RECV_STALL: return 53;
            PH_BOTH:       return 29;
            default:       return 0;
        endcase
    endfunction

    // random value: mostly a chosen digit count, some raw words, some extremes
    function automatic logic [VW-1:0] random_value();
        int          kind;
        int          nd;
        longint      lo;
        longint      hi;
        longint      mag;
        int unsigned r;
        kind = $urandom_range(0, 9);
        if (kind < 4)
            return $urandom;
        if (kind == 9)
        begin
            case ($urandom_range(0, 4))
                0:       return '0;
                1:       return '1;
                2:       return {1'b1, {(VW-1){1'b0}}};
                3:       return {1'b0, {(VW-1){1'b1}}};
                default: return $urandom_range(0, 1) ? 32'd1000000000 : -32'sd1000000000;
            endcase
        end
        nd = $urandom_range(1, 10);
        lo = 1;
        for (int i = 1; i < nd; i++)
            lo = lo * 10;
        hi = lo * 10 - 1;
        if (hi > 64'd2147483647)
            hi = 64'd2147483647;
        r   = $urandom;
        mag = lo + (longint'(r) % (hi - lo + 1));
        return $urandom_range(0, 1) ? VW'(-mag) : VW'(mag);
    endfunction

    // directed rows: extremes, digit boundaries and alternating bit patterns
    initial
    begin
        row_value[0]  = 32'd0;              row_text[0]  = "0";
        row_value[1]  = 32'd1;              row_text[1]  = "1";
        row_value[2]  = -32'sd1;            row_text[2]  = "-1";
        row_value[3]  = 32'd9;              row_text[3]  = "9";
        row_value[4]  = -32'sd9;            row_text[4]  = "-9";
        row_value[5]  = 32'd10;             row_text[5]  = "10";
        row_value[6]  = -32'sd10;           row_text[6]  = "-10";
        row_value[7]  = 32'd99;             row_text[7]  = "99";
        row_value[8]  = 32'd100;            row_text[8]  = "100";
        row_value[9]  = 32'h7FFF_FFFF;      row_text[9]  = "2147483647";
        row_value[10] = 32'h8000_0001;      row_text[10] = "-2147483647";
        row_value[11] = 32'h8000_0000;      row_text[11] = "-2147483648";
        row_value[12] = 32'd1000000000;     row_text[12] = "1000000000";
        row_value[13] = -32'sd1000000000;   row_text[13] = "-1000000000";
        row_value[14] = 32'd999999999;      row_text[14] = "999999999";
        row_value[15] = 32'd1234567890;     row_text[15] = "1234567890";
        row_value[16] = 32'h5555_5555;      row_text[16] = "";
        row_value[17] = 32'hAAAA_AAAA;      row_text[17] = "";
        row_value[18] = 32'h0F0F_0F0F;      row_text[18] = "";
        row_value[19] = 32'hF0F0_F0F0;      row_text[19] = "";
        row_value[20] = 32'h0001_0000;      row_text[20] = "";
        row_value[21] = 32'hFFFF_0000;      row_text[21] = "";
        row_value[22] = 32'd65535;          row_text[22] = "";
        row_value[23] = -32'sd12345;        row_text[23] = "";
    end

    // source side: hold each beat until accepted, idle by phase
    always @(posedge clk)
    begin
        value_item_t nxt;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                values_sent++;
                if (presented.value[VW-1])
                    negatives++;
                if (presented.typed)
                    push_typed_text(row_text[presented.row]);
                else
                    predict_decimal_text(presented.value);
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_values.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct(pending_values[0].pace))
                begin
                    nxt       = pending_values.pop_front();
                    presented <= nxt;
                    cur_pace  <= nxt.pace;
                    s_tdata   <= DATA_W'(nxt.value);
                    s_tvalid  <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink side: check each character beat against the oldest expectation
    always @(posedge clk)
    begin
        char_beat_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                beats_seen++;
                if (m_tlast)
                    numbers_seen++;
                if (expected_chars.size() == 0)
                begin
                    report_mismatch("character beat with nothing expected", m_tdata, -1);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (m_tdata !== want.ch)
                        report_mismatch("out_char", m_tdata, want.ch);
                    if (m_tlast !== want.last)
                        report_mismatch("last_char", m_tlast, want.last);
                    if (m_tuser !== want.count)
                        report_mismatch("digit_count", m_tuser, want.count);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct(cur_pace));
        end
    end

    // stimulus build, reset, drain and verdict
    initial
    begin
        value_item_t item;
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            item.value = row_value[i];
            item.typed = (row_text[i].len() != 0);
            item.row   = 5'(i);
            item.pace  = PH_FREE;
            pending_values.push_back(item);
        end
        // random values over the four pressure phases
        for (int p = 0; p < 4; p++)
        begin
            for (int i = 0; i < ((p == 0) ? 80 : 90); i++)
            begin
                item.value = random_value();
                item.typed = 1'b0;
                item.row   = '0;
                item.pace  = pace_t'(p);
                pending_values.push_back(item);
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        fork
            begin
                while (pending_values.size() != 0 || s_tvalid || expected_chars.size() != 0)
                    @(posedge clk);
                repeat (DRAIN_CYCLES) @(posedge clk);
                drained = 1'b1;
            end
            begin
                while (cycle_count < LIMIT_CYCLES)
                    @(posedge clk);
            end
        join_any

        if (!drained)
            report_mismatch("timeout, character beats still expected",
                            expected_chars.size(), 0);
        else if (expected_chars.size() != 0)
            report_mismatch("character beats never delivered", 0, expected_chars.size());

        $display("converted %0d values (%0d negative) into %0d character beats, %0d numbers",
                 values_sent, negatives, beats_seen, numbers_seen);
        $display("directed extremes and digit boundaries, then random values, four pacings");
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
sv/sitda_pkg.sv
sv/sitda_cell.sv
sv/sitda_ctrl.sv
sv/signed_int_to_decimal_ascii_top.sv
dv/signed_int_to_decimal_ascii_top_test.sv
